### hw/rtl/wts_pkg.sv
// Package for the windowed temperature statistics block.
// Holds the window geometry, derived widths, reset marks and the sequencer
// state type. No dependencies.
package wts_pkg;

  localparam int unsigned WINDOW      = 360;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned TIME_BITS   = 32;

  localparam int unsigned SLOT_W  = $clog2(WINDOW);
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned STEP_W  = $clog2(SUM_W);

  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(WINDOW);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(SUM_W - 1);

  localparam logic signed [SAMPLE_BITS-1:0] MARK_HIGH_RESET = -SAMPLE_BITS'(9999);
  localparam logic signed [SAMPLE_BITS-1:0] MARK_LOW_RESET  = SAMPLE_BITS'(9999);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SETUP,
    ST_DIVIDE,
    ST_DONE
  } wts_state_e;

endpackage

### hw/rtl/wts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module wts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 360
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

### hw/rtl/windowed_temperature_stats.sv
// Windowed temperature statistics: moving-window average and all-time peaks.
// Depends on wts_pkg and wts_ram.
//
// Usage: each request on the input channel (in_valid_i/in_ready_o) carries a
// signed sample and its timestamp. The block stores the sample in a ring of
// the last WINDOW samples, updates the running window sum and the all-time
// high and low marks, and produces exactly one result on the output channel
// (out_valid_o/out_ready_i): window average (truncated toward zero), peaks
// with their timestamps, and the current fill count.
// A request passes from acceptance through ST_READ, ST_UPDATE, ST_SETUP,
// ST_DIVIDE and ST_DONE to the result register. The ring read, the sum
// update and a restoring divider that retires one quotient bit per cycle run
// in sequence, so the block takes one request at a time: a new request is
// accepted only once the previous one has left ST_DONE.
// A finished result waits in the output register; the next request is taken
// and worked on meanwhile, and only its final hand-off waits for the receiver.
// Reset clears the window (count, slot and sum), sets the high mark to -9999
// and the low mark to 9999 with timestamps of zero, and empties the output.
module windowed_temperature_stats
  import wts_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [TIME_BITS-1:0]          sample_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] window_average_o,
  output logic signed [SAMPLE_BITS-1:0] peak_high_o,
  output logic [TIME_BITS-1:0]          peak_high_time_o,
  output logic signed [SAMPLE_BITS-1:0] peak_low_o,
  output logic [TIME_BITS-1:0]          peak_low_time_o,
  output logic [CNT_W-1:0]              fill_count_o
);

  wts_state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [TIME_BITS-1:0]          time_q;
  logic [SLOT_W-1:0]             slot_q, slot_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] high_q, high_d, low_q, low_d;
  logic [TIME_BITS-1:0]          high_time_q, high_time_d, low_time_q, low_time_d;

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                          out_load;

  logic                   in_accept;
  logic                   ring_wr;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUM_W-1:0] old_ext, new_ext;
  logic [CNT_W:0]         trial;
  logic                   trial_ge;
  logic [SAMPLE_BITS-1:0] quo_low;

  assign in_accept = in_valid_i && in_ready_o;

  wts_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (ring_wr),
    .wr_addr_i(slot_q),
    .wr_data_i(sample_q),
    .rd_en_i  (in_accept),
    .rd_addr_i(slot_q),
    .rd_data_o(old_sample)
  );

  assign old_ext = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
  assign new_ext = {{(SUM_W - SAMPLE_BITS){sample_q[SAMPLE_BITS-1]}}, sample_q};

  // One restoring division step: shift in the next dividend bit and subtract
  // the count when the partial remainder reaches it.
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = trial >= {1'b0, count_q};
  assign quo_low  = quo_q[SAMPLE_BITS-1:0];

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    count_d     = count_q;
    sum_d       = sum_q;
    high_d      = high_q;
    low_d       = low_q;
    high_time_d = high_time_q;
    low_time_d  = low_time_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    neg_d       = neg_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q;
    ring_wr     = 1'b0;
    in_ready_o  = 1'b0;
    out_load    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // The ring read issued at acceptance lands in this cycle's edge.
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        ring_wr = 1'b1;
        if (count_q == CNT_FULL) begin
          sum_d = sum_q - old_ext + new_ext;
        end else begin
          sum_d   = sum_q + new_ext;
          count_d = count_q + CNT_W'(1);
        end
        slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
        if (sample_q > high_q) begin
          high_d      = sample_q;
          high_time_d = time_q;
        end
        if (sample_q < low_q) begin
          low_d      = sample_q;
          low_time_d = time_q;
        end
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        neg_d   = sum_q[SUM_W-1];
        quo_d   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
        rem_d   = '0;
        step_d  = STEP_FIRST;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        rem_d = trial_ge ? CNT_W'(trial - {1'b0, count_q}) : CNT_W'(trial);
        quo_d = {quo_q[SUM_W-2:0], trial_ge};
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          avg_d       = neg_q ? -quo_low : quo_low;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      high_q      <= MARK_HIGH_RESET;
      low_q       <= MARK_LOW_RESET;
      high_time_q <= '0;
      low_time_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      high_q      <= high_d;
      low_q       <= low_d;
      high_time_q <= high_time_d;
      low_time_q  <= low_time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
      time_q   <= sample_time_i;
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    avg_q  <= avg_d;
    if (out_load) begin
      peak_high_o      <= high_q;
      peak_high_time_o <= high_time_q;
      peak_low_o       <= low_q;
      peak_low_time_o  <= low_time_q;
      fill_count_o     <= count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign window_average_o = avg_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("window fill count exceeds the window size");

  a_slot_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_LAST)
    else $error("ring write slot out of range");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the hand-off state");

  a_result_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_count_o != '0)
    else $error("result reports an empty window");
`endif

endmodule

### sim/tb_top.sv
// Testbench for windowed_temperature_stats: moving-window average and all-time peaks.
// Depends on wts_pkg and the block's RTL. A built-in predictor computes each expected
// result, and every result the block returns is checked against it in order.
`timescale 1ns / 1ps

module tb_top;
  import wts_pkg::*;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] average;
    logic signed [SAMPLE_BITS-1:0] high;
    logic [TIME_BITS-1:0]          high_time;
    logic signed [SAMPLE_BITS-1:0] low;
    logic [TIME_BITS-1:0]          low_time;
    logic [CNT_W-1:0]              fill;
  } window_stats_t;

  typedef enum int {
    MIX_UNIFORM,
    MIX_HOT,
    MIX_COLD,
    MIX_NEAR_ZERO,
    MIX_STEADY,
    MIX_MARK_EDGE
  } sample_mix_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic [TIME_BITS-1:0]          sample_time_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SAMPLE_BITS-1:0] window_average_o;
  logic signed [SAMPLE_BITS-1:0] peak_high_o;
  logic [TIME_BITS-1:0]          peak_high_time_o;
  logic signed [SAMPLE_BITS-1:0] peak_low_o;
  logic [TIME_BITS-1:0]          peak_low_time_o;
  logic [CNT_W-1:0]              fill_count_o;

  // Predictor state, starting from the reset values.
  logic signed [SAMPLE_BITS-1:0] ring_copy [WINDOW];
  int unsigned                   next_slot = 0;
  int unsigned                   held = 0;
  longint                        window_sum = 0;
  logic signed [SAMPLE_BITS-1:0] high_mark = MARK_HIGH_RESET;
  logic signed [SAMPLE_BITS-1:0] low_mark = MARK_LOW_RESET;
  logic [TIME_BITS-1:0]          high_mark_time = '0;
  logic [TIME_BITS-1:0]          low_mark_time = '0;

  window_stats_t stats_due[$];
  int            err_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  windowed_temperature_stats dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .sample_time_i   (sample_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .window_average_o(window_average_o),
    .peak_high_o     (peak_high_o),
    .peak_high_time_o(peak_high_time_o),
    .peak_low_o      (peak_low_o),
    .peak_low_time_o (peak_low_time_o),
    .fill_count_o    (fill_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("windowed_temperature_stats test failed");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Folds one accepted sample into the window and queues the result it must produce.
  task automatic update_window_stats(input logic signed [SAMPLE_BITS-1:0] temp,
                                     input logic [TIME_BITS-1:0] stamp);
    window_stats_t want;
    if (held >= WINDOW) begin
      window_sum -= ring_copy[next_slot];
    end else begin
      held++;
    end
    ring_copy[next_slot] = temp;
    window_sum += temp;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    if (temp > high_mark) begin
      high_mark = temp;
      high_mark_time = stamp;
    end
    if (temp < low_mark) begin
      low_mark = temp;
      low_mark_time = stamp;
    end
    // Signed integer division truncates toward zero, as the block must.
    want.average = SAMPLE_BITS'(window_sum / longint'(held));
    want.high = high_mark;
    want.high_time = high_mark_time;
    want.low = low_mark;
    want.low_time = low_mark_time;
    want.fill = CNT_W'(held);
    stats_due.push_back(want);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] temp,
                             input logic [TIME_BITS-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    sample_i <= temp;
    sample_time_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    update_window_stats(temp, stamp);
  endtask

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    window_stats_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual average %0d count %0d",
                 $time, window_average_o, fill_count_o);
        err_count++;
      end else begin
        want = stats_due.pop_front();
        check_field("window_average", want.average, window_average_o);
        check_field("peak_high", want.high, peak_high_o);
        check_field("peak_high_time", want.high_time, peak_high_time_o);
        check_field("peak_low", want.low, peak_low_o);
        check_field("peak_low_time", want.low_time, peak_low_time_o);
        check_field("fill_count", want.fill, fill_count_o);
      end
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input sample_mix_e mix, input logic signed [SAMPLE_BITS-1:0] base);
    int x;
    case (mix)
      MIX_HOT:       x = 32767 - int'($urandom_range(0, 300));
      MIX_COLD:      x = -32768 + int'($urandom_range(0, 300));
      MIX_NEAR_ZERO: x = int'($urandom_range(0, 64)) - 32;
      MIX_STEADY:    x = base;
      MIX_MARK_EDGE: x = ($urandom_range(1) ? 9999 : -9999) + int'($urandom_range(0, 4)) - 2;
      default:       x = int'($urandom);
    endcase
    return SAMPLE_BITS'(x);
  endfunction

  // The high mark stays at its reset value while every sample is at or below it,
  // then ties on both marks and the extremes of both fields.
  task automatic test_peak_marks_and_ties();
    logic signed [SAMPLE_BITS-1:0] temps [16] = '{
      -16'sd9999, -16'sd32768, -16'sd10000, -16'sd9999, -16'sd9998, -16'sd32768,
      16'sd32767, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd2, 16'sd9999, 16'sd9998,
      16'sh5555, 16'shAAAA};
    logic [TIME_BITS-1:0] stamps [16] = '{
      32'hFFFF_FFFF, 32'd0, 32'd5, 32'd6, 32'd7, 32'd8, 32'hFFFF_FFFF, 32'd9,
      32'd10, 32'd11, 32'd12, 32'd13, 32'd14, 32'd15, 32'h5555_5555, 32'hAAAA_AAAA};
    send_idle_pct = 12;
    recv_stall_pct = 50;
    for (int k = 0; k < 16; k++) begin
      send_sample(temps[k], stamps[k]);
    end
  endtask

  // Segments of random samples. One long segment runs past the window length with a
  // single kind of sample, so the sum can reach its extremes and oldest samples drop.
  task automatic test_random_window(input int items, input int idle_s, input int idle_r,
                                    input sample_mix_e long_mix);
    int                            done;
    int                            seg_len;
    bit                            long_done;
    bit                            steady_clock;
    sample_mix_e                   mix;
    logic signed [SAMPLE_BITS-1:0] base;
    logic [TIME_BITS-1:0]          stamp;
    done = 0;
    long_done = 1'b0;
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    stamp = $urandom;
    while (done < items) begin
      if (!long_done && done >= 20) begin
        mix = long_mix;
        seg_len = WINDOW + $urandom_range(10, 60);
        long_done = 1'b1;
      end else begin
        mix = sample_mix_e'($urandom_range(0, 5));
        seg_len = $urandom_range(1, 60);
      end
      base = SAMPLE_BITS'($urandom);
      steady_clock = $urandom_range(1);
      for (int k = 0; k < seg_len && done < items; k++) begin
        if (steady_clock) begin
          stamp += $urandom_range(25, 35);
        end else begin
          stamp = $urandom;
        end
        send_sample(pick_sample(mix, base), stamp);
        done++;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    sample_time_i = '0;
    out_ready_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_peak_marks_and_ties();
    test_random_window(430, 12, 50, MIX_HOT);
    test_random_window(430, 50, 12, MIX_COLD);
    test_random_window(430, 0, 0, MIX_STEADY);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk_i);
    repeat (SUM_W + 10) @(posedge clk_i);

    if (err_count == 0) begin
      $display("windowed_temperature_stats test passed");
    end else begin
      $display("windowed_temperature_stats test failed");
    end
    $finish;
  end

endmodule
